// File: rtl/core/ktt_pkg.sv
// ----------------------------------------------------------------------------
// ktt_pkg
// Shared types and constants for the keyed timeout table: request codes,
// field widths and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ktt_pkg;

  // Default table depth
  localparam int unsigned ENTRIES_DEF = 16;

  // Field widths
  localparam int unsigned REQ_W   = 3;
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned LIMIT_W = 32;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned USED_W  = 5;

  // Stream widths
  localparam int unsigned S_DATA_W = KEY_W + LIMIT_W;  // 64 bits
  localparam int unsigned M_DATA_W = 8;                // flag + used, padded

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_SET   = 3'd0,
    REQ_CHECK = 3'd1,
    REQ_CLEAR = 3'd2,
    REQ_SWEEP = 3'd3,
    REQ_TICK  = 3'd4
  } req_e;

  // Controller -> datapath
  typedef struct packed {
    logic load;     // capture key/limit, restart the scan
    logic scan;     // issue a table read at the scan index
    logic arm;      // write key/limit/start, mark active
    logic arm_new;  // with arm: append at fill count and grow it
    logic deact;    // clear the active bit of the entry just read
    logic tick;     // advance the millisecond counter
  } ktt_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic              rd_vld;      // read data of one entry is present
    logic              rd_match;    // that entry holds the requested key
    logic              rd_active;   // that entry is active
    logic              rd_expired;  // that entry's elapsed time exceeds its limit
    logic              scan_end;    // all occupied entries have been issued
    logic              full;        // no free entry left
    logic [USED_W-1:0] used;        // fill count, low bits
  } ktt_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/ktt_dp.sv
// ----------------------------------------------------------------------------
// ktt_dp
// Datapath: entry memories, active bits, millisecond counter, fill count and
// the scan pipeline (one registered memory read per cycle, compare next cycle).
// ----------------------------------------------------------------------------
`default_nettype none

module ktt_dp #(
  parameter int unsigned ENTRIES = ktt_pkg::ENTRIES_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire ktt_pkg::ktt_cmd_t            cmd_i,
  input  wire logic [ktt_pkg::KEY_W-1:0]    key_i,
  input  wire logic [ktt_pkg::LIMIT_W-1:0]  limit_i,
  output ktt_pkg::ktt_stat_t                stat_o
);

  localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(ENTRIES + 1);

  // Entry storage, no reset: only entries below the fill count are read
  logic [ktt_pkg::KEY_W-1:0]   mem_key   [ENTRIES];
  logic [ktt_pkg::LIMIT_W-1:0] mem_limit [ENTRIES];
  logic [ktt_pkg::TIME_W-1:0]  mem_start [ENTRIES];

  logic [ENTRIES-1:0]          active_q, active_d;
  logic [ktt_pkg::TIME_W-1:0]  now_q;
  logic [CntW-1:0]             fill_q;
  logic [CntW-1:0]             idx_q;
  logic                        rd_vld_q;
  logic [IdxW-1:0]             rd_idx_q;
  logic [ktt_pkg::KEY_W-1:0]   rd_key_q;
  logic [ktt_pkg::LIMIT_W-1:0] rd_limit_q;
  logic [ktt_pkg::TIME_W-1:0]  rd_start_q;
  logic [ktt_pkg::KEY_W-1:0]   key_q;
  logic [ktt_pkg::LIMIT_W-1:0] limit_q;

  logic                        scan_end;
  logic                        full;
  logic [IdxW-1:0]             wr_addr;
  logic [ktt_pkg::TIME_W-1:0]  elapsed;

  assign scan_end = (idx_q >= fill_q);
  assign full     = (fill_q == CntW'(ENTRIES));
  assign wr_addr  = cmd_i.arm_new ? fill_q[IdxW-1:0] : rd_idx_q;
  assign elapsed  = now_q - rd_start_q;

  // Active bits: arm sets, deactivate clears the entry just read
  always_comb begin
    active_d = active_q;
    if (cmd_i.deact) begin
      active_d[rd_idx_q] = 1'b0;
    end
    if (cmd_i.arm) begin
      active_d[wr_addr] = 1'b1;
    end
  end

  // Control state of the datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      now_q    <= '0;
      fill_q   <= '0;
      idx_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      active_q <= active_d;
      if (cmd_i.tick) begin
        now_q <= now_q + ktt_pkg::TIME_W'(1);
      end
      if (cmd_i.arm && cmd_i.arm_new) begin
        fill_q <= fill_q + CntW'(1);
      end
      if (cmd_i.load) begin
        idx_q    <= '0;
        rd_vld_q <= 1'b0;
      end else begin
        rd_vld_q <= cmd_i.scan && !scan_end;
        if (cmd_i.scan && !scan_end) begin
          idx_q <= idx_q + CntW'(1);
        end
      end
    end
  end

  // Request operands and scan index of the pending read
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q   <= key_i;
      limit_q <= limit_i;
    end
    if (cmd_i.scan) begin
      rd_idx_q <= idx_q[IdxW-1:0];
    end
  end

  // Memory: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.arm) begin
      mem_key[wr_addr]   <= key_q;
      mem_limit[wr_addr] <= limit_q;
      mem_start[wr_addr] <= now_q;
    end
    if (cmd_i.scan && !scan_end) begin
      rd_key_q   <= mem_key[idx_q[IdxW-1:0]];
      rd_limit_q <= mem_limit[idx_q[IdxW-1:0]];
      rd_start_q <= mem_start[idx_q[IdxW-1:0]];
    end
  end

  // Status toward the controller
  always_comb begin
    stat_o.rd_vld     = rd_vld_q;
    stat_o.rd_match   = rd_vld_q && (rd_key_q == key_q);
    stat_o.rd_active  = active_q[rd_idx_q];
    stat_o.rd_expired = (elapsed > rd_limit_q);
    stat_o.scan_end   = scan_end;
    stat_o.full       = full;
    stat_o.used       = ktt_pkg::USED_W'(fill_q);
  end

endmodule

`default_nettype wire

// File: rtl/core/ktt_ctrl.sv
// ----------------------------------------------------------------------------
// ktt_ctrl
// Controller: takes request beats, steers the datapath scan, decides the
// flag and holds the output register of the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module ktt_ctrl (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_tvalid_i,
  output logic                              s_tready_o,
  input  wire logic [ktt_pkg::REQ_W-1:0]    s_req_i,
  output logic                              m_tvalid_o,
  input  wire logic                         m_tready_i,
  output logic                              m_flag_o,
  output logic [ktt_pkg::USED_W-1:0]        m_used_o,
  output ktt_pkg::ktt_cmd_t                 cmd_o,
  input  wire ktt_pkg::ktt_stat_t           stat_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e                       state_q;
  ktt_pkg::req_e                req_q;
  logic                         flag_q;
  logic                         m_valid_q;
  logic                         m_flag_q;
  logic [ktt_pkg::USED_W-1:0]   m_used_q;

  logic                         accept;
  logic                         is_search;
  logic                         finish;
  logic                         fin_flag;
  logic                         m_load;

  assign s_tready_o = (state_q == ST_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;
  assign m_tvalid_o = m_valid_q;
  assign m_flag_o   = m_flag_q;
  assign m_used_o   = m_used_q;

  // Result register takes a new beat when it is empty or being drained
  assign m_load     = (state_q == ST_DONE) && (!m_valid_q || m_tready_i);

  always_comb begin
    case (ktt_pkg::req_e'(s_req_i))
      ktt_pkg::REQ_SET,
      ktt_pkg::REQ_CHECK,
      ktt_pkg::REQ_CLEAR,
      ktt_pkg::REQ_SWEEP: is_search = 1'b1;
      default:            is_search = 1'b0;
    endcase
  end

  // Commands and end-of-scan decision
  always_comb begin
    cmd_o    = '0;
    finish   = 1'b0;
    fin_flag = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.load = is_search;
          cmd_o.tick = (ktt_pkg::req_e'(s_req_i) == ktt_pkg::REQ_TICK);
        end
      end
      ST_SCAN: begin
        if (stat_i.rd_match && (req_q != ktt_pkg::REQ_SWEEP)) begin
          // first entry holding the key
          finish = 1'b1;
          case (req_q)
            ktt_pkg::REQ_SET: begin
              cmd_o.arm = 1'b1;
              fin_flag  = 1'b1;
            end
            ktt_pkg::REQ_CHECK: begin
              if (stat_i.rd_active && stat_i.rd_expired) begin
                cmd_o.deact = 1'b1;
                fin_flag    = 1'b1;
              end
            end
            ktt_pkg::REQ_CLEAR: cmd_o.deact = 1'b1;
            default:            cmd_o.deact = 1'b0;
          endcase
        end else begin
          cmd_o.scan = 1'b1;
          if ((req_q == ktt_pkg::REQ_SWEEP) && stat_i.rd_vld &&
              stat_i.rd_active && stat_i.rd_expired) begin
            cmd_o.deact = 1'b1;
          end
          if (stat_i.scan_end && !stat_i.rd_vld) begin
            // key not present: a set appends when room is left
            finish = 1'b1;
            if ((req_q == ktt_pkg::REQ_SET) && !stat_i.full) begin
              cmd_o.arm     = 1'b1;
              cmd_o.arm_new = 1'b1;
              fin_flag      = 1'b1;
            end
          end
        end
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // State and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      req_q     <= ktt_pkg::REQ_SET;
      flag_q    <= 1'b0;
      m_valid_q <= 1'b0;
      m_flag_q  <= 1'b0;
      m_used_q  <= '0;
    end else begin
      if (m_load) begin
        m_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            req_q  <= ktt_pkg::req_e'(s_req_i);
            flag_q <= 1'b0;
            state_q <= is_search ? ST_SCAN : ST_DONE;
          end
        end
        ST_SCAN: begin
          if (finish) begin
            flag_q  <= fin_flag;
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (m_load) begin
            m_flag_q  <= flag_q;
            m_used_q  <= stat_i.used;
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/keyed_timeout_table.sv
// ----------------------------------------------------------------------------
// keyed_timeout_table
// Table of keyed timeouts against a millisecond counter advanced by tick
// requests: set/re-arm, check expiry, clear, sweep expired entries.
//
//   channel   dir  tdata                          tuser
//   s_axis    in   [31:0] key, [63:32] limit_ms   [2:0] req_type
//   m_axis    out  [0] flag, [5:1] used_entries   -
//
// Set, check, clear and sweep scan the occupied entries through one memory
// read port, one entry a cycle; a hit on the key ends the scan early for
// set, check and clear. Tick and unused codes skip the scan and go straight
// to the result. Reset clears the counter, the fill count and the active
// bits at once; the entry memory needs no clearing pass. A result waiting
// in the output register does not block the next request beat, only the
// one after it.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_timeout_table #(
  parameter int unsigned ENTRIES = ktt_pkg::ENTRIES_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [ktt_pkg::S_DATA_W-1:0]   s_axis_tdata,  // key, limit_ms
  input  wire logic [ktt_pkg::REQ_W-1:0]      s_axis_tuser,  // req_type
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [ktt_pkg::M_DATA_W-1:0]        m_axis_tdata   // flag, used_entries
);

  ktt_pkg::ktt_cmd_t              cmd;
  ktt_pkg::ktt_stat_t             stat;
  logic                           m_flag;
  logic [ktt_pkg::USED_W-1:0]     m_used;

  ktt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_req_i    (s_axis_tuser),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_flag_o   (m_flag),
    .m_used_o   (m_used),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  ktt_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .key_i   (s_axis_tdata[ktt_pkg::KEY_W-1:0]),
    .limit_i (s_axis_tdata[ktt_pkg::S_DATA_W-1:ktt_pkg::KEY_W]),
    .stat_o  (stat)
  );

  assign m_axis_tdata = {
    (ktt_pkg::M_DATA_W - ktt_pkg::USED_W - 1)'(0), m_used, m_flag
  };

  // One request at a time: an accepted beat closes the input
  a_one_at_a_time : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request accepted while another is in progress");

  // Never append to a full table
  a_no_append_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.full |-> !(cmd.arm && cmd.arm_new))
    else $error("append issued on a full table");

  // Fill count only grows, one step at a time
  a_fill_step : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.used != $past(stat.used)) |->
      (stat.used == $past(stat.used) + ktt_pkg::USED_W'(1)))
    else $error("fill count moved by other than one");

  // Table operations only run while a search request is in progress
  a_cmd_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !(cmd.arm || cmd.deact || cmd.scan))
    else $error("table operation while idle");

endmodule

`default_nettype wire
